// File: src/aem_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the allocation event monitor.
// No dependencies; the top level and the testbench import this package.
package aem_pkg;

    localparam int SIZE_W = 48;
    localparam int TIME_W = 32;
    localparam int SEQ_W  = 32;
    localparam int NET_W  = 64;
    localparam int CNT_W  = 48;
    localparam int RIDX_W = 9;
    localparam int MODE_W = 3;
    localparam int OP_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_ALLOC     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REALLOC   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FREE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ_CLS  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_RING = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_FLOOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_CEILING = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] new_size;
        logic [SIZE_W-1:0] prior_size;
        logic [SIZE_W-1:0] caller_addr;
        logic [TIME_W-1:0] time_ms;
        logic [RIDX_W-1:0] read_index;
    } item_t;

    typedef struct packed {
        logic                     banked;
        logic [SEQ_W-1:0]         sequence_res;
        logic signed [NET_W-1:0]  class_net;
        logic [CNT_W-1:0]         class_allocs;
        logic [CNT_W-1:0]         class_frees;
        logic [OP_W-1:0]          rec_op;
        logic [TIME_W-1:0]        rec_time;
        logic [SIZE_W-1:0]        rec_new_size;
        logic [SIZE_W-1:0]        rec_prior_size;
        logic [SIZE_W-1:0]        rec_addr;
        logic signed [NET_W-1:0]  net_total;
    } result_t;

    typedef struct packed {
        logic [NET_W-1:0] net;
        logic [CNT_W-1:0] allocs;
        logic [CNT_W-1:0] frees;
    } cls_entry_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
        logic [SIZE_W-1:0] new_size;
        logic [SIZE_W-1:0] prior_size;
        logic [SIZE_W-1:0] addr;
    } rec_t;

endpackage

// File: src/aem_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module aem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/alloc_event_monitor.sv
`timescale 1ns / 1ps
// Top level of the allocation event monitor: size-class histogram and trace ring.
// Depends on aem_pkg and aem_ram.
//
//  channel   handshake          payload    notes
//  command   start / busy       cmd        taken when start is high and busy is low
//  result    done (strobe)      result     one cycle per result, cannot be held off
//  config    cfg_we             cfg_index, cfg_data   written on the edge, no read-back
//
// An alloc, realloc or free keeps busy high through RD_NEW, WR_NEW, RD_OLD and WR_OLD
// after its transfer; reads and unused modes pass through RD_NEW and WR_NEW only.
// A new command is taken only once busy has fallen. The states follow the single
// class memory, which is read and then written for the new side and again for the
// old side. Reset clears the histogram through per-class valid bits, so no clearing
// pass is needed. The result strobe comes in the first cycle with busy low again.
module alloc_event_monitor
    import aem_pkg::*;
#(
    parameter int RING_DEPTH  = 512,
    parameter int NUM_CLASSES = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                cmd,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    localparam int CLS_AW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RD_NEW = 3'd1;
    localparam logic [2:0] ST_WR_NEW = 3'd2;
    localparam logic [2:0] ST_RD_OLD = 3'd3;
    localparam logic [2:0] ST_WR_OLD = 3'd4;

    function automatic logic [5:0] msb_pos(input logic [SIZE_W-1:0] size);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < SIZE_W; i++)
        begin
            if (size[i])
            begin
                pos = 6'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [CLS_AW-1:0] size_class(input logic [SIZE_W-1:0] size);
        logic [5:0] pos;
        pos = msb_pos(size);
        if ({1'b0, pos} >= 7'(NUM_CLASSES))
        begin
            return CLS_AW'(NUM_CLASSES - 1);
        end
        return CLS_AW'(pos);
    endfunction

    logic [2:0]             state_reg, state_next;
    item_t                  item_reg;
    logic [SIZE_W-1:0]      class_floor_reg, trace_floor_reg, trace_ceiling_reg;
    logic [NUM_CLASSES-1:0] cls_valid_reg;
    logic [SEQ_W-1:0]       rec_cnt_reg;
    logic [RING_AW-1:0]     slot_reg;
    logic [NET_W-1:0]       net_total_reg;
    logic [NET_W-1:0]       delta_reg;
    logic                   traced_reg;
    logic [SEQ_W-1:0]       seq_reg;
    logic                   done_reg;
    result_t                res_reg, res_next;

    logic                   accept;
    logic                   is_event;
    logic                   book_new, book_old;
    logic                   traced_now;
    logic [CLS_AW-1:0]      cls_addr;
    logic                   cls_we;
    cls_entry_t             cls_wdata, cls_rdata, cls_cur;
    logic                   cls_rd_ok;
    logic                   ring_we;
    rec_t                   ring_wdata, ring_rdata;
    logic [RING_AW-1:0]     ring_raddr;
    logic                   ring_rd_ok;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign result   = res_reg;
    assign is_event = (item_reg.mode <= MODE_FREE);

    assign book_new = is_event && (class_floor_reg != '0)
                      && (item_reg.new_size >= class_floor_reg);
    assign book_old = is_event && (class_floor_reg != '0)
                      && (item_reg.prior_size >= class_floor_reg);

    assign traced_now = is_event && (trace_floor_reg != '0)
        && (((item_reg.new_size >= trace_floor_reg)
             && ((trace_ceiling_reg == '0) || (item_reg.new_size <= trace_ceiling_reg)))
         || ((item_reg.prior_size >= trace_floor_reg)
             && ((trace_ceiling_reg == '0) || (item_reg.prior_size <= trace_ceiling_reg))));

    always_comb
    begin
        if ((state_reg == ST_RD_OLD) || (state_reg == ST_WR_OLD))
        begin
            cls_addr = size_class(item_reg.prior_size);
        end
        else if (is_event)
        begin
            cls_addr = size_class(item_reg.new_size);
        end
        else
        begin
            cls_addr = CLS_AW'(item_reg.read_index);
        end
    end

    assign cls_rd_ok = (10'(item_reg.read_index) < 10'(NUM_CLASSES));
    assign cls_cur   = cls_valid_reg[cls_addr] ? cls_rdata : '0;

    always_comb
    begin
        cls_wdata = cls_cur;
        cls_we    = 1'b0;
        if (state_reg == ST_WR_NEW)
        begin
            cls_we           = book_new;
            cls_wdata.net    = cls_cur.net + NET_W'(item_reg.new_size);
            cls_wdata.allocs = cls_cur.allocs + CNT_W'(1);
        end
        else if (state_reg == ST_WR_OLD)
        begin
            cls_we          = book_old;
            cls_wdata.net   = cls_cur.net - NET_W'(item_reg.prior_size);
            cls_wdata.frees = cls_cur.frees + CNT_W'(1);
        end
    end

    aem_ram #(
        .WIDTH ($bits(cls_entry_t)),
        .DEPTH (NUM_CLASSES)
    ) u_cls_ram (
        .clk   (clk),
        .we    (cls_we),
        .waddr (cls_addr),
        .wdata (cls_wdata),
        .raddr (cls_addr),
        .rdata (cls_rdata)
    );

    assign ring_raddr = RING_AW'(item_reg.read_index);
    assign ring_rd_ok = (17'(item_reg.read_index) < 17'(RING_DEPTH));
    assign ring_we    = (state_reg == ST_WR_NEW) && is_event && traced_reg;

    always_comb
    begin
        ring_wdata.op         = item_reg.mode[OP_W-1:0];
        ring_wdata.seq        = rec_cnt_reg;
        ring_wdata.stamp      = item_reg.time_ms;
        ring_wdata.new_size   = item_reg.new_size;
        ring_wdata.prior_size = item_reg.prior_size;
        ring_wdata.addr       = item_reg.caller_addr;
    end

    aem_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (slot_reg),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD_NEW;
                end
            end
            ST_RD_NEW:
            begin
                state_next = ST_WR_NEW;
            end
            ST_WR_NEW:
            begin
                state_next = is_event ? ST_RD_OLD : ST_IDLE;
            end
            ST_RD_OLD:
            begin
                state_next = ST_WR_OLD;
            end
            ST_WR_OLD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_next = '0;
        res_next.net_total = net_total_reg;
        if (state_reg == ST_WR_OLD)
        begin
            res_next.banked       = traced_reg;
            res_next.sequence_res = traced_reg ? seq_reg : '0;
        end
        else if (item_reg.mode == MODE_READ_CLS)
        begin
            if (cls_rd_ok)
            begin
                res_next.class_net    = cls_cur.net;
                res_next.class_allocs = cls_cur.allocs;
                res_next.class_frees  = cls_cur.frees;
            end
        end
        else if (item_reg.mode == MODE_READ_RING)
        begin
            if (ring_rd_ok)
            begin
                res_next.sequence_res   = ring_rdata.seq;
                res_next.rec_op         = ring_rdata.op;
                res_next.rec_time       = ring_rdata.stamp;
                res_next.rec_new_size   = ring_rdata.new_size;
                res_next.rec_prior_size = ring_rdata.prior_size;
                res_next.rec_addr       = ring_rdata.addr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            class_floor_reg   <= '0;
            trace_floor_reg   <= '0;
            trace_ceiling_reg <= '0;
            cls_valid_reg     <= '0;
            rec_cnt_reg       <= '0;
            slot_reg          <= '0;
            net_total_reg     <= '0;
            traced_reg        <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_WR_OLD)
                         || ((state_reg == ST_WR_NEW) && !is_event);

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLASS_FLOOR:   class_floor_reg   <= cfg_data;
                    CFG_TRACE_FLOOR:   trace_floor_reg   <= cfg_data;
                    CFG_TRACE_CEILING: trace_ceiling_reg <= cfg_data;
                    default:           ;
                endcase
            end

            if (cls_we)
            begin
                cls_valid_reg[cls_addr] <= 1'b1;
            end

            if (state_reg == ST_RD_NEW)
            begin
                traced_reg <= traced_now;
            end

            if (ring_we)
            begin
                net_total_reg <= net_total_reg + delta_reg;
                rec_cnt_reg   <= rec_cnt_reg + SEQ_W'(1);
                if ((rec_cnt_reg == '1) || (32'(slot_reg) == 32'(RING_DEPTH - 1)))
                begin
                    slot_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_reg + RING_AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
        if (state_reg == ST_RD_NEW)
        begin
            delta_reg <= ((item_reg.mode != MODE_FREE) ? NET_W'(item_reg.new_size) : '0)
                       - ((item_reg.mode != MODE_ALLOC) ? NET_W'(item_reg.prior_size) : '0);
        end
        if (state_reg == ST_WR_NEW)
        begin
            seq_reg <= rec_cnt_reg;
        end
        res_reg <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of an operation");

    a_ring_event_only: assert property (@(posedge clk) disable iff (!rst_n)
        ring_we |-> (item_reg.mode == MODE_ALLOC || item_reg.mode == MODE_REALLOC
                     || item_reg.mode == MODE_FREE))
        else $error("trace record written by a read or unused mode");

    a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ring_we |=> $stable(rec_cnt_reg))
        else $error("record counter moved without a trace transfer");

    a_banked_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.banked) |-> (result.sequence_res == rec_cnt_reg - SEQ_W'(1)))
        else $error("banked sequence number does not match the record counter");
`endif

endmodule

// File: dv/tb_alloc_event_monitor.sv
`timescale 1ns / 1ps
// Self-checking testbench for alloc_event_monitor: directed and random event streams,
// each result checked field by field against a predictor of the histogram and trace ring.
// Depends on aem_pkg and the alloc_event_monitor RTL.
module tb_alloc_event_monitor;
    import aem_pkg::*;

    localparam int RING_SLOTS  = 512;
    localparam int NUM_CLS     = 48;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    item_t                cmd;
    logic                 done;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    logic [SIZE_W-1:0] cfg_class_floor;
    logic [SIZE_W-1:0] cfg_trace_floor;
    logic [SIZE_W-1:0] cfg_trace_ceiling;

    logic [NET_W-1:0] cls_net[NUM_CLS];
    logic [CNT_W-1:0] cls_allocs[NUM_CLS];
    logic [CNT_W-1:0] cls_frees[NUM_CLS];
    rec_t             ring[RING_SLOTS];
    logic [SEQ_W-1:0] rec_count;
    logic [NET_W-1:0] alloc_total;
    logic [NET_W-1:0] free_total;
    logic [NET_W-1:0] realloc_new_total;
    logic [NET_W-1:0] realloc_old_total;

    result_t outstanding[$];
    result_t result_want;
    int      idle_pct;
    int      fail_count;
    int      sent_count;
    int      checked_count;
    int      banked_count;
    int      cycle_count;

    alloc_event_monitor #(
        .RING_DEPTH  (RING_SLOTS),
        .NUM_CLASSES (NUM_CLS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int size_class_of(logic [SIZE_W-1:0] sz);
        int c;
        c = 0;
        for (int b = 1; b < SIZE_W; b++)
        begin
            if ((sz >> b) != 0)
                c = b;
        end
        return (c < NUM_CLS) ? c : NUM_CLS - 1;
    endfunction

    function automatic bit in_trace_band(logic [SIZE_W-1:0] sz);
        return sz >= cfg_trace_floor && (cfg_trace_ceiling == 0 || sz <= cfg_trace_ceiling);
    endfunction

    function automatic result_t apply_event(item_t it);
        result_t r;
        int      c;
        int      slot;
        r = '0;
        if (it.mode <= MODE_FREE)
        begin
            if (cfg_class_floor != 0)
            begin
                if (it.new_size >= cfg_class_floor)
                begin
                    c = size_class_of(it.new_size);
                    cls_net[c] = cls_net[c] + NET_W'(it.new_size);
                    cls_allocs[c] = cls_allocs[c] + 1'b1;
                end
                if (it.prior_size >= cfg_class_floor)
                begin
                    c = size_class_of(it.prior_size);
                    cls_net[c] = cls_net[c] - NET_W'(it.prior_size);
                    cls_frees[c] = cls_frees[c] + 1'b1;
                end
            end
            if (cfg_trace_floor != 0
                && (in_trace_band(it.new_size) || in_trace_band(it.prior_size)))
            begin
                if (it.mode == MODE_FREE)
                    free_total = free_total + NET_W'(it.prior_size);
                else if (it.mode == MODE_REALLOC)
                begin
                    realloc_new_total = realloc_new_total + NET_W'(it.new_size);
                    realloc_old_total = realloc_old_total + NET_W'(it.prior_size);
                end
                else
                    alloc_total = alloc_total + NET_W'(it.new_size);
                slot = int'(rec_count % RING_SLOTS);
                ring[slot].op         = it.mode[OP_W-1:0];
                ring[slot].seq        = rec_count;
                ring[slot].stamp      = it.time_ms;
                ring[slot].new_size   = it.new_size;
                ring[slot].prior_size = it.prior_size;
                ring[slot].addr       = it.caller_addr;
                r.banked       = 1'b1;
                r.sequence_res = rec_count;
                rec_count      = rec_count + 1'b1;
                banked_count++;
            end
        end
        else if (it.mode == MODE_READ_CLS)
        begin
            if (it.read_index < NUM_CLS)
            begin
                r.class_net    = cls_net[it.read_index];
                r.class_allocs = cls_allocs[it.read_index];
                r.class_frees  = cls_frees[it.read_index];
            end
        end
        else if (it.mode == MODE_READ_RING)
        begin
            if (it.read_index < RING_SLOTS)
            begin
                r.sequence_res   = ring[it.read_index].seq;
                r.rec_op         = ring[it.read_index].op;
                r.rec_time       = ring[it.read_index].stamp;
                r.rec_new_size   = ring[it.read_index].new_size;
                r.rec_prior_size = ring[it.read_index].prior_size;
                r.rec_addr       = ring[it.read_index].addr;
            end
        end
        r.net_total = alloc_total + realloc_new_total - realloc_old_total - free_total;
        return r;
    endfunction

    function automatic item_t make_item(logic [MODE_W-1:0] mode, logic [SIZE_W-1:0] nsz,
                                        logic [SIZE_W-1:0] osz, logic [SIZE_W-1:0] addr,
                                        logic [TIME_W-1:0] tms, logic [RIDX_W-1:0] ridx);
        item_t it;
        it.mode        = mode;
        it.new_size    = nsz;
        it.prior_size  = osz;
        it.caller_addr = addr;
        it.time_ms     = tms;
        it.read_index  = ridx;
        return it;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        logic [SIZE_W-1:0] near;
        near = SIZE_W'($urandom_range(0, 2)) - 1'b1;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SIZE_W'($urandom_range(1, 255));
            2: return (SIZE_W'(1) << $urandom_range(0, SIZE_W - 1)) + near;
            3: return SIZE_W'({$urandom(), $urandom()});
            4: return SIZE_MAX;
            5: return cfg_trace_floor + near;
            6: return cfg_trace_ceiling + near;
            default: return cfg_class_floor + near;
        endcase
    endfunction

    function automatic item_t random_event();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        it.caller_addr = SIZE_W'({$urandom(), $urandom()});
        it.time_ms     = $urandom();
        it.read_index  = RIDX_W'($urandom());
        it.new_size    = '0;
        it.prior_size  = '0;
        if (pick < 25)
        begin
            it.mode     = MODE_ALLOC;
            it.new_size = pick_size();
            if ($urandom_range(0, 9) == 0)
                it.prior_size = pick_size();
        end
        else if (pick < 45)
        begin
            it.mode       = MODE_REALLOC;
            it.new_size   = pick_size();
            it.prior_size = pick_size();
        end
        else if (pick < 65)
        begin
            it.mode       = MODE_FREE;
            it.prior_size = pick_size();
            if ($urandom_range(0, 9) == 0)
                it.new_size = pick_size();
        end
        else if (pick < 93 && (pick < 78 || rec_count == 0))
        begin
            it.mode = MODE_READ_CLS;
            if ($urandom_range(0, 4) != 0)
                it.read_index = RIDX_W'($urandom_range(0, NUM_CLS - 1));
        end
        else if (pick < 93)
        begin
            it.mode = MODE_READ_RING;
            if (rec_count < RING_SLOTS)
                it.read_index = RIDX_W'($urandom_range(0, rec_count - 1));
        end
        else
        begin
            it.mode       = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            it.new_size   = pick_size();
            it.prior_size = pick_size();
        end
        return it;
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR: %s", msg);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
            note_failure($sformatf("result %0d, %s: expected %h, got %h",
                                   checked_count, name, want, got));
    endtask

    task automatic compare_results(result_t got, result_t want);
        check_field("banked", want.banked, got.banked);
        check_field("sequence_res", want.sequence_res, got.sequence_res);
        check_field("class_net", want.class_net, got.class_net);
        check_field("class_allocs", want.class_allocs, got.class_allocs);
        check_field("class_frees", want.class_frees, got.class_frees);
        check_field("rec_op", want.rec_op, got.rec_op);
        check_field("rec_time", want.rec_time, got.rec_time);
        check_field("rec_new_size", want.rec_new_size, got.rec_new_size);
        check_field("rec_prior_size", want.rec_prior_size, got.rec_prior_size);
        check_field("rec_addr", want.rec_addr, got.rec_addr);
        check_field("net_total", want.net_total, got.net_total);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outstanding.size() == 0)
                note_failure("result strobe with no outstanding event");
            else
            begin
                result_want = outstanding.pop_front();
                compare_results(result, result_want);
            end
            checked_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, outstanding.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic send_event(item_t it);
        start <= 1'b1;
        cmd   <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        outstanding.push_back(apply_event(it));
        sent_count++;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            pause_sender(1);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (outstanding.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_CLASS_FLOOR:   cfg_class_floor   = value;
            CFG_TRACE_FLOOR:   cfg_trace_floor   = value;
            CFG_TRACE_CEILING: cfg_trace_ceiling = value;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_disarmed();
        write_reg(CFG_CLASS_FLOOR, '0);
        write_reg(CFG_TRACE_FLOOR, '0);
        write_reg(CFG_TRACE_CEILING, '0);
        send_event(make_item(MODE_ALLOC, SIZE_MAX, '0, SIZE_MAX, '1, '1));
        send_event(make_item(MODE_REALLOC, 48'd4096, 48'd64, 48'h1000, 32'd5, '0));
        send_event(make_item(MODE_FREE, '0, SIZE_MAX, '0, '0, '0));
        send_event(make_item(MODE_READ_CLS, '0, '0, '0, '0, 9'd0));
        send_event(make_item(MODE_READ_CLS, '0, '0, '0, '0, 9'(NUM_CLS - 1)));
        settle();
    endtask

    task automatic test_directed_events();
        write_reg(CFG_CLASS_FLOOR, 48'd1);
        write_reg(CFG_TRACE_FLOOR, 48'd1);
        write_reg(CFG_TRACE_CEILING, '0);
        send_event(make_item(MODE_ALLOC, SIZE_MAX, '0, SIZE_MAX, '1, '1));
        send_event(make_item(MODE_ALLOC, 48'd1, '0, '0, '0, '0));
        send_event(make_item(MODE_REALLOC, 48'h8000_0000_0000, 48'd3, 48'h1234_5678_9abc,
                             32'd1000, 9'd7));
        send_event(make_item(MODE_FREE, '0, SIZE_MAX, 48'hfff0, 32'hffff_fffe, '0));
        send_event(make_item(MODE_ALLOC, '0, '0, 48'h42, 32'd9, '0));
        send_event(make_item(MODE_FREE, 48'd5, 48'd7, 48'h77, 32'd10, '1));
        send_event(make_item(MODE_SPARE_FIRST, SIZE_MAX, SIZE_MAX, SIZE_MAX, '1, '1));
        send_event(make_item(MODE_SPARE_MID, 48'd8, 48'd8, 48'd8, 32'd8, 9'd0));
        send_event(make_item(MODE_SPARE_LAST, 48'd100, '0, '0, '0, 9'd1));
        send_event(make_item(MODE_READ_CLS, '0, '0, '0, '0, 9'd0));
        send_event(make_item(MODE_READ_CLS, '0, '0, '0, '0, 9'd1));
        send_event(make_item(MODE_READ_CLS, '0, '0, '0, '0, 9'(NUM_CLS - 1)));
        send_event(make_item(MODE_READ_CLS, '0, '0, '0, '0, 9'(NUM_CLS)));
        send_event(make_item(MODE_READ_CLS, '0, '0, '0, '0, '1));
        for (int i = 0; i < 4; i++)
        begin
            send_event(make_item(MODE_READ_RING, '0, '0, '0, '0, 9'(i)));
        end
        settle();
    endtask

    task automatic test_trace_band();
        write_reg(CFG_CLASS_FLOOR, SIZE_MAX);
        write_reg(CFG_TRACE_FLOOR, 48'd100);
        write_reg(CFG_TRACE_CEILING, 48'd200);
        send_event(make_item(MODE_ALLOC, 48'd99, '0, 48'h1, 32'd1, '0));
        send_event(make_item(MODE_ALLOC, 48'd100, '0, 48'h2, 32'd2, '0));
        send_event(make_item(MODE_ALLOC, 48'd200, '0, 48'h3, 32'd3, '0));
        send_event(make_item(MODE_ALLOC, 48'd201, SIZE_MAX, 48'h4, 32'd4, '0));
        send_event(make_item(MODE_REALLOC, 48'd50, 48'd150, 48'h5, 32'd5, '0));
        send_event(make_item(MODE_READ_CLS, '0, '0, '0, '0, 9'(NUM_CLS - 1)));
        settle();
        write_reg(CFG_TRACE_CEILING, 48'd50);
        send_event(make_item(MODE_FREE, '0, 48'd100, 48'h6, 32'd6, '0));
        send_event(make_item(MODE_READ_RING, '0, '0, '0, '0, 9'(rec_count - 1)));
        settle();
    endtask

    task automatic test_random_light_gaps();
        idle_pct = 26;
        write_reg(CFG_CLASS_FLOOR, SIZE_W'($urandom_range(1, 1 << 16)));
        write_reg(CFG_TRACE_FLOOR, SIZE_W'($urandom_range(1, 1 << 12)));
        write_reg(CFG_TRACE_CEILING, cfg_trace_floor + SIZE_W'($urandom_range(0, 1 << 20)));
        repeat (120) send_event(random_event());
        settle();
    endtask

    task automatic test_random_heavy_gaps();
        idle_pct = 65;
        write_reg(CFG_CLASS_FLOOR, SIZE_W'(1) << $urandom_range(4, 40));
        write_reg(CFG_TRACE_FLOOR, SIZE_W'($urandom_range(1, 1 << 30)));
        write_reg(CFG_TRACE_CEILING, '0);
        repeat (120) send_event(random_event());
        settle();
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        write_reg(CFG_CLASS_FLOOR, 48'd1);
        write_reg(CFG_TRACE_FLOOR, 48'd1);
        write_reg(CFG_TRACE_CEILING, SIZE_MAX);
        repeat (180) send_event(random_event());
        settle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cfg_class_floor   = '0;
        cfg_trace_floor   = '0;
        cfg_trace_ceiling = '0;
        for (int i = 0; i < NUM_CLS; i++)
        begin
            cls_net[i]    = '0;
            cls_allocs[i] = '0;
            cls_frees[i]  = '0;
        end
        rec_count         = '0;
        alloc_total       = '0;
        free_total        = '0;
        realloc_new_total = '0;
        realloc_old_total = '0;
        idle_pct      = 0;
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        banked_count  = 0;
        cycle_count   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disarmed();
        test_directed_events();
        test_trace_band();
        test_random_light_gaps();
        test_random_heavy_gaps();
        test_back_to_back();

        repeat (20) @(posedge clk);
        if (outstanding.size() != 0)
            note_failure($sformatf("%0d results never arrived", outstanding.size()));
        $display("Sent %0d events and reads, checked %0d results, %0d trace records banked.",
                 sent_count, checked_count, banked_count);
        $display("Record counter ended at %0d; %0d cycles; %0d failures.",
                 rec_count, cycle_count, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
